// ===== hdl/atu_pkg.sv =====
// Shared types, constants and helpers for the affine transform unit.
package atu_pkg;

   localparam int COEFF_WIDTH = 32;
   localparam int FRAC_BITS   = 16;
   localparam int NUM_COEFFS  = 12;
   localparam int NUM_COFS    = 9;
   // operand width: a coefficient minus a translation, or the reciprocal
   localparam int OPW         = COEFF_WIDTH + 2;
   localparam int PRODW       = 2 * OPW - FRAC_BITS;
   localparam int ACCW        = PRODW + 2;
   localparam int DIV_QW      = 2 * FRAC_BITS + 1;
   localparam int DIV_CW      = $clog2(DIV_QW);
   localparam logic signed [OPW-1:0] FX_ONE = OPW'(1) <<< FRAC_BITS;

   localparam logic [2:0] KIND_LOAD      = 3'd0;
   localparam logic [2:0] KIND_POINT     = 3'd1;
   localparam logic [2:0] KIND_INV_POINT = 3'd2;
   localparam logic [2:0] KIND_DIR       = 3'd3;
   localparam logic [2:0] KIND_INV_DIR   = 3'd4;
   localparam logic [2:0] KIND_INVERT    = 3'd5;
   localparam logic [2:0] KIND_DET       = 3'd6;

   typedef struct packed {
      logic [2:0]                    kind;
      logic [3:0]                    coeff_index;
      logic signed [COEFF_WIDTH-1:0] coeff_value;
      logic signed [COEFF_WIDTH-1:0] in_x;
      logic signed [COEFF_WIDTH-1:0] in_y;
      logic signed [COEFF_WIDTH-1:0] in_z;
   } req_type;

   typedef struct packed {
      logic signed [COEFF_WIDTH-1:0] out_x;
      logic signed [COEFF_WIDTH-1:0] out_y;
      logic signed [COEFF_WIDTH-1:0] out_z;
      logic signed [COEFF_WIDTH-1:0] determinant;
      logic                          status;
   } rsp_type;

   typedef enum logic [2:0] {SRC_M, SRC_COF, SRC_V, SRC_RECIP, SRC_ONE} src_type;
   typedef enum logic [1:0] {DST_COF, DST_DET, DST_OUT, DST_M} dst_type;

   // one multiply-accumulate step of the sequencer
   typedef struct packed {
      src_type    a_src;
      logic [3:0] a_idx;
      src_type    b_src;
      logic [3:0] b_idx;
      logic       sub;
      logic       first;
      logic       last;
      dst_type    dst;
      logic [3:0] dst_idx;
   } op_type;

   // minor pairs: cofactor j = M[A(2j)]*M[B(2j)] - M[A(2j+1)]*M[B(2j+1)]
   localparam logic [3:0] COF_AI [18] = '{
      4'd5, 4'd6, 4'd6, 4'd4, 4'd4, 4'd5, 4'd2, 4'd1, 4'd0,
      4'd2, 4'd1, 4'd0, 4'd1, 4'd2, 4'd2, 4'd0, 4'd0, 4'd1};
   localparam logic [3:0] COF_BI [18] = '{
      4'd10, 4'd9, 4'd8, 4'd10, 4'd9, 4'd8, 4'd9, 4'd10, 4'd10,
      4'd8, 4'd8, 4'd9, 4'd6, 4'd5, 4'd4, 4'd6, 4'd5, 4'd4};

   function automatic logic signed [COEFF_WIDTH-1:0] sat_coeff(
      input logic signed [ACCW-1:0] v);
      logic [ACCW-COEFF_WIDTH:0] hi;
      hi = v[ACCW-1:COEFF_WIDTH-1];
      if ((&hi) || (~|hi))
         return v[COEFF_WIDTH-1:0];
      else if (v[ACCW-1])
         return {1'b1, {(COEFF_WIDTH-1){1'b0}}};
      else
         return {1'b0, {(COEFF_WIDTH-1){1'b1}}};
   endfunction

endpackage

// ===== hdl/affine_transform_unit_top.sv =====
// Top level of the affine transform unit: sequencer, shared multiplier and divider.
//
// Holds a 3x4 affine matrix of Q16.16 coefficients and runs one operation per
// request word: coefficient load, point or direction transform, inverse point or
// direction transform, in-place inversion, or determinant read.
// Request words enter on req_valid/req_stall, response words leave on
// rsp_valid/rsp_stall; a word moves when valid is high and stall is low.
// One request is worked at a time; req_stall stays high until its response
// word sits in the output register. The output register frees the sequencer,
// so the next request is taken while a response still waits for the receiver.
// Every operation is a chain of multiply-accumulate steps on one 34x34
// multiplier; each step fetches operand a, then operand b, then multiplies,
// with the add in the cycle after. The determinant always runs first: 21 steps.
// An inversion adds a restoring divide and 18 more steps. A stalled receiver
// holds the response word; a finished request then waits in its last state
// until the register frees.
// Synchronous reset clears the matrix to zero and drops any pending response.
module affine_transform_unit_top
   import atu_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   typedef enum logic [2:0] {S_IDLE, S_RUN, S_SETTLE, S_CHECK, S_DIV, S_FIN, S_OUT}
      state_type;
   typedef enum logic [2:0] {SEG_COF, SEG_DET, SEG_FWD, SEG_TRN, SEG_NR, SEG_T}
      seg_type;

   state_type state_ff;
   seg_type   seg_ff;
   logic [4:0] k_ff;
   logic [1:0] ph_ff;

   logic [2:0] kind_ff;
   logic [3:0] load_idx_ff;
   logic signed [COEFF_WIDTH-1:0] load_val_ff;

   logic signed [COEFF_WIDTH-1:0] m_ff   [NUM_COEFFS];
   logic signed [COEFF_WIDTH-1:0] cof_ff [NUM_COFS];
   logic signed [COEFF_WIDTH-1:0] out_ff [3];
   logic signed [COEFF_WIDTH-1:0] det_ff;
   logic signed [OPW-1:0]         v_ff   [3];
   logic signed [OPW-1:0]         recip_ff;
   logic                          status_ff;

   logic signed [OPW-1:0]   opa_ff, opb_ff;
   logic signed [PRODW-1:0] prod_ff;
   op_type                  prod_op_ff;
   logic                    prod_vld_ff;
   logic signed [ACCW-1:0]  acc_ff;

   logic [COEFF_WIDTH-1:0] div_rem_ff, div_dvsr_ff;
   logic [DIV_QW-1:0]      div_q_ff;
   logic [DIV_CW-1:0]      div_cnt_ff;
   logic                   div_neg_ff;

   logic    rsp_valid_ff;
   rsp_type rsp_data_ff;

   op_type  op;
   logic [1:0] row, col, last_col;
   src_type opnd_src;
   logic [3:0] opnd_idx;
   logic signed [OPW-1:0] opnd;
   logic signed [2*OPW-1:0] prod_full;
   logic signed [ACCW-1:0] acc_base, acc_in;
   logic signed [COEFF_WIDTH-1:0] acc_sat;
   logic [COEFF_WIDTH:0] div_shift, div_diff;
   logic div_ge;
   logic [DIV_QW-1:0] div_q_in;

   assign row = k_ff[3:2];
   assign col = k_ff[1:0];
   assign last_col = (seg_ff == SEG_FWD && kind_ff == KIND_POINT) ? 2'd3 : 2'd2;

   // build the current step from segment and step counter
   always_comb begin
      op = '0;
      unique case (seg_ff)
         SEG_COF: begin
            op.a_src   = SRC_M;
            op.a_idx   = COF_AI[k_ff];
            op.b_src   = SRC_M;
            op.b_idx   = COF_BI[k_ff];
            op.sub     = k_ff[0];
            op.first   = ~k_ff[0];
            op.last    = k_ff[0];
            op.dst     = DST_COF;
            op.dst_idx = 4'(k_ff[4:1]);
         end
         SEG_DET: begin
            op.a_src   = SRC_M;
            op.a_idx   = k_ff[3:0];
            op.b_src   = SRC_COF;
            op.b_idx   = k_ff[3:0];
            op.first   = (k_ff == 5'd0);
            op.last    = (k_ff == 5'd2);
            op.dst     = DST_DET;
         end
         SEG_FWD: begin
            op.a_src   = SRC_M;
            op.a_idx   = {row, col};
            op.b_src   = (col == 2'd3) ? SRC_ONE : SRC_V;
            op.b_idx   = {2'b00, col};
            op.first   = (col == 2'd0);
            op.last    = (col == last_col);
            op.dst     = DST_OUT;
            op.dst_idx = {2'b00, row};
         end
         SEG_TRN: begin
            op.a_src   = SRC_M;
            op.a_idx   = {col, row};
            op.b_src   = SRC_V;
            op.b_idx   = {2'b00, col};
            op.first   = (col == 2'd0);
            op.last    = (col == 2'd2);
            op.dst     = DST_OUT;
            op.dst_idx = {2'b00, row};
         end
         SEG_NR: begin
            op.a_src   = SRC_COF;
            op.a_idx   = {1'b0, col, 1'b0} + {2'b00, col} + {2'b00, row};
            op.b_src   = SRC_RECIP;
            op.first   = 1'b1;
            op.last    = 1'b1;
            op.dst     = DST_M;
            op.dst_idx = {row, col};
         end
         SEG_T: begin
            op.a_src   = SRC_M;
            op.a_idx   = {row, col};
            op.b_src   = SRC_V;
            op.b_idx   = {2'b00, col};
            op.sub     = 1'b1;
            op.first   = (col == 2'd0);
            op.last    = (col == 2'd2);
            op.dst     = DST_M;
            op.dst_idx = {row, 2'd3};
         end
         default: op = '0;
      endcase
   end

   // one operand fetch per cycle: a in phase 0, b in phase 1
   always_comb begin
      opnd_src = (ph_ff == 2'd0) ? op.a_src : op.b_src;
      opnd_idx = (ph_ff == 2'd0) ? op.a_idx : op.b_idx;
      unique case (opnd_src)
         SRC_M:     opnd = OPW'(m_ff[opnd_idx]);
         SRC_COF:   opnd = OPW'(cof_ff[opnd_idx]);
         SRC_V:     opnd = v_ff[opnd_idx[1:0]];
         SRC_RECIP: opnd = recip_ff;
         SRC_ONE:   opnd = FX_ONE;
         default:   opnd = '0;
      endcase
   end

   assign prod_full = opa_ff * opb_ff;

   // accumulate in the cycle after the product is registered
   assign acc_base = prod_op_ff.first ? '0 : acc_ff;
   assign acc_in   = prod_op_ff.sub ? acc_base - ACCW'(prod_ff) : acc_base + ACCW'(prod_ff);
   assign acc_sat  = sat_coeff(acc_in);

   // restoring divide of 1.0*1.0 by |det|, one quotient bit per cycle
   assign div_shift = {div_rem_ff, (div_cnt_ff == DIV_CW'(DIV_QW - 1))};
   assign div_diff  = div_shift - {1'b0, div_dvsr_ff};
   assign div_ge    = (div_shift >= {1'b0, div_dvsr_ff});
   assign div_q_in  = {div_q_ff[DIV_QW-2:0], div_ge};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         prod_vld_ff  <= 1'b0;
         seg_ff       <= SEG_COF;
         k_ff         <= '0;
         ph_ff        <= '0;
         for (int i = 0; i < NUM_COEFFS; i++)
            m_ff[i] <= '0;
      end else begin
         // drop the word once taken, unless a new one loads this cycle
         if (rsp_valid_ff && !rsp_stall && state_ff != S_OUT)
            rsp_valid_ff <= 1'b0;

         prod_vld_ff <= 1'b0;
         if (prod_vld_ff) begin
            acc_ff <= acc_in;
            if (prod_op_ff.last) begin
               unique case (prod_op_ff.dst)
                  DST_COF: cof_ff[prod_op_ff.dst_idx] <= acc_sat;
                  DST_DET: det_ff <= acc_sat;
                  DST_OUT: out_ff[prod_op_ff.dst_idx[1:0]] <= acc_sat;
                  DST_M:   m_ff[prod_op_ff.dst_idx] <= acc_sat;
                  default: ;
               endcase
            end
         end

         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  kind_ff     <= req_data.kind;
                  load_idx_ff <= req_data.coeff_index;
                  load_val_ff <= req_data.coeff_value;
                  status_ff   <= 1'b0;
                  for (int i = 0; i < 3; i++)
                     out_ff[i] <= '0;
                  if (req_data.kind == KIND_INV_POINT) begin
                     v_ff[0] <= OPW'(req_data.in_x) - OPW'(m_ff[3]);
                     v_ff[1] <= OPW'(req_data.in_y) - OPW'(m_ff[7]);
                     v_ff[2] <= OPW'(req_data.in_z) - OPW'(m_ff[11]);
                  end else if (req_data.kind == KIND_INVERT) begin
                     // hold the old translation for the new one
                     v_ff[0] <= OPW'(m_ff[3]);
                     v_ff[1] <= OPW'(m_ff[7]);
                     v_ff[2] <= OPW'(m_ff[11]);
                  end else begin
                     v_ff[0] <= OPW'(req_data.in_x);
                     v_ff[1] <= OPW'(req_data.in_y);
                     v_ff[2] <= OPW'(req_data.in_z);
                  end
                  seg_ff   <= SEG_COF;
                  k_ff     <= '0;
                  ph_ff    <= '0;
                  state_ff <= S_RUN;
               end
            end
            S_RUN: begin
               unique case (ph_ff)
                  2'd0: begin
                     opa_ff <= opnd;
                     ph_ff  <= 2'd1;
                  end
                  2'd1: begin
                     opb_ff <= opnd;
                     ph_ff  <= 2'd2;
                  end
                  default: begin
                     prod_ff     <= prod_full[2*OPW-1:FRAC_BITS];
                     prod_op_ff  <= op;
                     prod_vld_ff <= 1'b1;
                     ph_ff       <= 2'd0;
                     unique case (seg_ff)
                        SEG_COF: begin
                           if (k_ff == 5'd17) begin
                              seg_ff <= SEG_DET;
                              k_ff   <= '0;
                           end else begin
                              k_ff <= k_ff + 5'd1;
                           end
                        end
                        SEG_DET: begin
                           if (k_ff == 5'd2) begin
                              k_ff <= '0;
                              priority if (kind_ff == KIND_POINT || kind_ff == KIND_DIR)
                                 seg_ff <= SEG_FWD;
                              else if (kind_ff == KIND_INV_POINT ||
                                       kind_ff == KIND_INV_DIR)
                                 seg_ff <= SEG_TRN;
                              else if (kind_ff == KIND_INVERT)
                                 state_ff <= S_SETTLE;
                              else
                                 state_ff <= S_FIN;
                           end else begin
                              k_ff <= k_ff + 5'd1;
                           end
                        end
                        default: begin
                           // row by row, column by column
                           if (col == last_col) begin
                              if (row == 2'd2) begin
                                 k_ff <= '0;
                                 if (seg_ff == SEG_NR)
                                    seg_ff <= SEG_T;
                                 else
                                    state_ff <= S_FIN;
                              end else begin
                                 k_ff <= {1'b0, row + 2'd1, 2'd0};
                              end
                           end else begin
                              k_ff <= {1'b0, row, col + 2'd1};
                           end
                        end
                     endcase
                  end
               endcase
            end
            S_SETTLE: state_ff <= S_CHECK;
            S_CHECK: begin
               if (det_ff == '0) begin
                  status_ff <= 1'b1;
                  state_ff  <= S_FIN;
               end else begin
                  div_dvsr_ff <= det_ff[COEFF_WIDTH-1] ? COEFF_WIDTH'(-det_ff)
                                                       : COEFF_WIDTH'(det_ff);
                  div_neg_ff  <= det_ff[COEFF_WIDTH-1];
                  div_rem_ff  <= '0;
                  div_q_ff    <= '0;
                  div_cnt_ff  <= DIV_CW'(DIV_QW - 1);
                  state_ff    <= S_DIV;
               end
            end
            S_DIV: begin
               div_rem_ff <= div_ge ? div_diff[COEFF_WIDTH-1:0]
                                    : div_shift[COEFF_WIDTH-1:0];
               div_q_ff   <= div_q_in;
               div_cnt_ff <= div_cnt_ff - DIV_CW'(1);
               if (div_cnt_ff == '0) begin
                  recip_ff <= div_neg_ff ? -OPW'(div_q_in) : OPW'(div_q_in);
                  seg_ff   <= SEG_NR;
                  k_ff     <= '0;
                  ph_ff    <= '0;
                  state_ff <= S_RUN;
               end
            end
            S_FIN: state_ff <= S_OUT;
            S_OUT: begin
               // wait here while the receiver holds the previous word
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_valid_ff            <= 1'b1;
                  rsp_data_ff.out_x       <= out_ff[0];
                  rsp_data_ff.out_y       <= out_ff[1];
                  rsp_data_ff.out_z       <= out_ff[2];
                  rsp_data_ff.determinant <= det_ff;
                  rsp_data_ff.status      <= status_ff;
                  if (kind_ff == KIND_LOAD && load_idx_ff < 4'(NUM_COEFFS))
                     m_ff[load_idx_ff] <= load_val_ff;
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
